### design/mvt_pkg.sv
package mvt_pkg;

    // Matrix size and fixed-point format
    localparam int DIM       = 4;
    localparam int FRAC_BITS = 16;

    // Fixed field widths and counts
    localparam int NCOMP     = 4;
    localparam int NREGS     = 8;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_W     = 64;
    localparam int Q_W       = 32;
    localparam int PROD_W    = 2 * Q_W;
    localparam int NPAIR     = (DIM + 1) / 2;
    localparam int PAIR_W    = PROD_W + 1;
    localparam int ACC_W     = PROD_W + $clog2(DIM);
    localparam int SAT_LSB   = FRAC_BITS + Q_W - 1;

    localparam logic [Q_W-1:0] SAT_MAX = {1'b0, {(Q_W-1){1'b1}}};
    localparam logic [Q_W-1:0] SAT_MIN = {1'b1, {(Q_W-1){1'b0}}};

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_R0_C01 = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_R3_C23 = CFG_IDX_W'(NREGS - 1);

    // Reset values: identity matrix, 1.0 = 0x00010000
    localparam logic [CFG_W-1:0] ONE_LO = CFG_W'(64'h0000_0000_0001_0000);
    localparam logic [CFG_W-1:0] ONE_HI = CFG_W'(64'h0001_0000_0000_0000);

    typedef logic [Q_W-1:0] qword_t;
    typedef qword_t [DIM-1:0] qrow_t;

    typedef struct packed {
        logic signed [Q_W-1:0] vec_x;
        logic signed [Q_W-1:0] vec_y;
        logic signed [Q_W-1:0] vec_z;
        logic signed [Q_W-1:0] vec_w;
    } vec_t;

    typedef struct packed {
        logic signed [Q_W-1:0] out_x;
        logic signed [Q_W-1:0] out_y;
        logic signed [Q_W-1:0] out_z;
        logic signed [Q_W-1:0] out_w;
    } res_t;

    // Per-stage load strobes shared by the lanes and the merge stage
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } mvt_adv_t;

endpackage

### design/mvt_lane.sv
module mvt_lane (
    input  logic              clk,
    input  mvt_pkg::mvt_adv_t adv,
    input  mvt_pkg::qrow_t    row,
    input  mvt_pkg::qrow_t    vec,
    output mvt_pkg::qword_t   res
);
    import mvt_pkg::*;

    logic signed [PROD_W-1:0] prod_reg [DIM];
    logic signed [PAIR_W-1:0] pair_reg [NPAIR];
    logic signed [PAIR_W-1:0] pair_next [NPAIR];
    logic signed [ACC_W-1:0]  sum_reg;
    logic signed [ACC_W-1:0]  sum_next;
    logic [ACC_W-SAT_LSB-1:0] sum_top;

    // Stage 1: one 32x32 signed multiply per column
    always_ff @(posedge clk)
    begin
        if (adv.s1)
        begin
            for (int c = 0; c < DIM; c++)
            begin
                prod_reg[c] <= $signed(row[c]) * $signed(vec[c]);
            end
        end
    end

    // Stage 2: add products in pairs
    for (genvar p = 0; p < NPAIR; p++) begin : g_pair
        if (2 * p + 1 < DIM) begin : g_two
            assign pair_next[p] = PAIR_W'(prod_reg[2*p]) + PAIR_W'(prod_reg[2*p+1]);
        end else begin : g_one
            assign pair_next[p] = PAIR_W'(prod_reg[2*p]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv.s2)
        begin
            for (int p = 0; p < NPAIR; p++)
            begin
                pair_reg[p] <= pair_next[p];
            end
        end
    end

    // Stage 3: full-precision sum, never wraps
    always_comb
    begin
        sum_next = '0;
        for (int p = 0; p < NPAIR; p++)
        begin
            sum_next = sum_next + ACC_W'(pair_reg[p]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv.s3)
        begin
            sum_reg <= sum_next;
        end
    end

    // Drop the fraction bits and clamp to 32 bits
    assign sum_top = sum_reg[ACC_W-1:SAT_LSB];

    always_comb
    begin
        if ((&sum_top) || !(|sum_top))
        begin
            res = sum_reg[SAT_LSB:FRAC_BITS];
        end
        else if (sum_reg[ACC_W-1])
        begin
            res = SAT_MIN;
        end
        else
        begin
            res = SAT_MAX;
        end
    end

endmodule

### design/mvt_merge.sv
module mvt_merge (
    input  logic              clk,
    input  mvt_pkg::mvt_adv_t adv,
    input  mvt_pkg::qrow_t    lane_res,
    output mvt_pkg::res_t     out_data
);
    import mvt_pkg::*;

    qword_t full [NCOMP];
    res_t   out_data_reg;
    res_t   out_data_next;

    // Rows past the matrix size read as zero
    for (genvar i = 0; i < NCOMP; i++) begin : g_row
        if (i < DIM) begin : g_used
            assign full[i] = lane_res[i];
        end else begin : g_zero
            assign full[i] = '0;
        end
    end

    always_comb
    begin
        out_data_next.out_x = full[0];
        out_data_next.out_y = full[1];
        out_data_next.out_z = full[2];
        out_data_next.out_w = full[3];
    end

    always_ff @(posedge clk)
    begin
        if (adv.s4)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_data = out_data_reg;

endmodule

### design/matrix_vector_transform_4x4_core.sv
// Streaming 4x4 matrix times 4-vector in signed Q16.16. Each input beat
// carries one vector; each output beat carries the four row dot products,
// each summed at full precision, shifted right by 16 (rounding toward minus
// infinity) and clamped to signed 32 bits. One vector enters per clock
// unless a full pipeline is held by out_ready; each result passes through
// registered stages in order (multiply loads at the input beat, then pair
// add, final add, clamp into the output register); the four row lanes of
// four multipliers each are fully pipelined.
// Empty pipeline stages keep accepting input while a result waits on
// out_ready.
// The matrix lives in eight 64-bit registers written through the cfg port
// (index 0..7, row-major, even column in bits 31:0, odd column in 63:32);
// they reset to the identity matrix. cfg_ready is always high, writes to
// indexes past 7 are dropped, and the matrix should only be changed while
// no vector is in flight.
module matrix_vector_transform_4x4_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  mvt_pkg::vec_t                   in_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output mvt_pkg::res_t                   out_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [mvt_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mvt_pkg::CFG_W-1:0]       cfg_data
);
    import mvt_pkg::*;

    logic [CFG_W-1:0] mat_reg [NREGS];

    logic v1_reg, v2_reg, v3_reg, out_valid_reg;
    logic v1_next, v2_next, v3_next, out_valid_next;
    logic free1, free2, free3, out_free;
    mvt_adv_t adv;

    qword_t vec_all [NCOMP];
    qrow_t  vec_row;
    qrow_t  mat_row [DIM];
    qrow_t  lane_res;

    // Matrix registers; reset to identity, ignore writes beyond the list
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mat_reg[0] <= ONE_LO;
            mat_reg[1] <= '0;
            mat_reg[2] <= ONE_HI;
            mat_reg[3] <= '0;
            mat_reg[4] <= '0;
            mat_reg[5] <= ONE_LO;
            mat_reg[6] <= '0;
            mat_reg[7] <= ONE_HI;
        end
        else if (cfg_valid && cfg_index <= REG_R3_C23)
        begin
            mat_reg[cfg_index[$clog2(NREGS)-1:0]] <= cfg_data;
        end
    end

    // Stage handshake: a stage loads when its successor frees up this cycle
    assign out_free = !out_valid_reg || out_ready;
    assign free3    = !v3_reg || out_free;
    assign free2    = !v2_reg || free3;
    assign free1    = !v1_reg || free2;

    assign in_ready = free1;

    always_comb
    begin
        adv.s1 = in_valid && free1;
        adv.s2 = v1_reg && free2;
        adv.s3 = v2_reg && free3;
        adv.s4 = v3_reg && out_free;
    end

    // Advance valid bits where the stage is free, otherwise hold
    assign v1_next        = free1    ? in_valid : v1_reg;
    assign v2_next        = free2    ? v1_reg   : v2_reg;
    assign v3_next        = free3    ? v2_reg   : v3_reg;
    assign out_valid_next = out_free ? v3_reg   : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            v1_reg        <= v1_next;
            v2_reg        <= v2_next;
            v3_reg        <= v3_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    // Unpack the input beat; components past the matrix size are ignored
    assign vec_all[0] = in_data.vec_x;
    assign vec_all[1] = in_data.vec_y;
    assign vec_all[2] = in_data.vec_z;
    assign vec_all[3] = in_data.vec_w;

    for (genvar c = 0; c < DIM; c++) begin : g_vec
        assign vec_row[c] = vec_all[c];
    end

    // One lane per row; each lane sees its row of entries split out of
    // the register pairs
    for (genvar r = 0; r < DIM; r++) begin : g_lane
        for (genvar c = 0; c < DIM; c++) begin : g_col
            if (c % 2 == 1) begin : g_hi
                assign mat_row[r][c] = mat_reg[r*2 + c/2][CFG_W-1:Q_W];
            end else begin : g_lo
                assign mat_row[r][c] = mat_reg[r*2 + c/2][Q_W-1:0];
            end
        end

        mvt_lane u_lane (
            .clk (clk),
            .adv (adv),
            .row (mat_row[r]),
            .vec (vec_row),
            .res (lane_res[r])
        );
    end

    // Gather the lane results into the output register
    mvt_merge u_merge (
        .clk      (clk),
        .adv      (adv),
        .lane_res (lane_res),
        .out_data (out_data)
    );

endmodule
